// File: design/cgw_pkg.sv
// Shared types, constants and codes for the gift-wrap convex hull block.
// Used by cgw_ctrl, cgw_datapath and convex_hull_gift_wrap_top; no dependencies.
package cgw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    // Operation codes of the func field.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // Status codes carried on every result word.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } cmd_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] hull_x;
        logic signed [COORD_BITS-1:0] hull_y;
        logic                         last_vertex;
        logic [1:0]                   status;
    } vtx_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEFT_RD,
        ST_LEFT_CMP,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_DIFF,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                mem_we;
        logic                mem_re;
        logic [IDX_BITS-1:0] mem_addr;
        logic                left_upd;
        logic                left_first;
        logic                cur_from_start;
        logic                load_best;
        logic                diff_en;
        logic                mul_en;
        logic                cmp_en;
        logic                advance;
        logic                out_load;
        logic                out_last;
        logic                out_zero;
        logic [1:0]          out_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic stop_hit;
    } stat_t;

endpackage

// File: design/cgw_datapath.sv
// Datapath of the hull block: point store, coordinate registers, cross and
// dot product pipeline and the result word register. Depends on cgw_pkg.
module cgw_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  cgw_pkg::cmd_t     cmd,
    output cgw_pkg::stat_t    stat,
    input  cgw_pkg::point_t   load_pt,
    output logic              vtx_valid,
    input  logic              vtx_stall,
    output cgw_pkg::vtx_word_t vtx_word
);

    logic [2*cgw_pkg::COORD_BITS-1:0] mem [cgw_pkg::MAX_POINTS];
    cgw_pkg::point_t rdata_reg;
    cgw_pkg::point_t start_reg;
    cgw_pkg::point_t cur_reg;
    cgw_pkg::point_t best_reg;

    logic signed [cgw_pkg::DIFF_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg, ex_reg, ey_reg;
    logic signed [cgw_pkg::DIFF_BITS-1:0] ax_next, ay_next, bx_next, by_next, ex_next, ey_next;
    logic signed [cgw_pkg::PROD_BITS-1:0] l_reg, r_reg, p1_reg, p2_reg;
    logic signed [cgw_pkg::SUM_BITS-1:0]  dot_sum;
    logic take;
    logic left_better;

    logic                vtx_valid_reg, vtx_valid_next;
    cgw_pkg::vtx_word_t  vtx_word_reg;

    // Point store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[cmd.mem_addr] <= load_pt;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= cgw_pkg::point_t'(mem[cmd.mem_addr]);
        end
    end

    // Leftmost point test: smaller x wins, on equal x the greater y wins.
    assign left_better = (rdata_reg.x < start_reg.x) ||
                         ((rdata_reg.x == start_reg.x) && (rdata_reg.y > start_reg.y));

    // Differences relative to the current vertex and the current best.
    always_comb
    begin
        ax_next = {best_reg.x[cgw_pkg::COORD_BITS-1], best_reg.x}
                - {cur_reg.x[cgw_pkg::COORD_BITS-1], cur_reg.x};
        ay_next = {best_reg.y[cgw_pkg::COORD_BITS-1], best_reg.y}
                - {cur_reg.y[cgw_pkg::COORD_BITS-1], cur_reg.y};
        bx_next = {rdata_reg.x[cgw_pkg::COORD_BITS-1], rdata_reg.x}
                - {cur_reg.x[cgw_pkg::COORD_BITS-1], cur_reg.x};
        by_next = {rdata_reg.y[cgw_pkg::COORD_BITS-1], rdata_reg.y}
                - {cur_reg.y[cgw_pkg::COORD_BITS-1], cur_reg.y};
        ex_next = {rdata_reg.x[cgw_pkg::COORD_BITS-1], rdata_reg.x}
                - {best_reg.x[cgw_pkg::COORD_BITS-1], best_reg.x};
        ey_next = {rdata_reg.y[cgw_pkg::COORD_BITS-1], rdata_reg.y}
                - {best_reg.y[cgw_pkg::COORD_BITS-1], best_reg.y};
    end

    // The candidate wins if it lies left of cur->best, or if it is collinear
    // and the best lies on the segment from cur to the candidate.
    assign dot_sum = {p1_reg[cgw_pkg::PROD_BITS-1], p1_reg}
                   + {p2_reg[cgw_pkg::PROD_BITS-1], p2_reg};
    assign take = (l_reg > r_reg) || ((l_reg == r_reg) && !dot_sum[cgw_pkg::SUM_BITS-1]);

    // Coordinate registers and product pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.left_upd && (cmd.left_first || left_better))
        begin
            start_reg <= rdata_reg;
        end
        if (cmd.cur_from_start)
        begin
            cur_reg <= start_reg;
        end
        else if (cmd.advance)
        begin
            cur_reg <= best_reg;
        end
        if (cmd.load_best || (cmd.cmp_en && take))
        begin
            best_reg <= rdata_reg;
        end
        if (cmd.diff_en)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            bx_reg <= bx_next;
            by_reg <= by_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end
        if (cmd.mul_en)
        begin
            l_reg  <= ax_reg * by_reg;
            r_reg  <= ay_reg * bx_reg;
            p1_reg <= ax_reg * ex_reg;
            p2_reg <= ay_reg * ey_reg;
        end
    end

    // The walk ends when the next vertex is the start or the current vertex.
    assign stat.stop_hit = (best_reg == start_reg) || (best_reg == cur_reg);
    assign stat.out_free = !vtx_valid_reg || !vtx_stall;

    // Output word register.
    always_comb
    begin
        vtx_valid_next = vtx_valid_reg;
        if (vtx_valid_reg && !vtx_stall)
        begin
            vtx_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            vtx_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid_reg <= 1'b0;
        end
        else
        begin
            vtx_valid_reg <= vtx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            vtx_word_reg.hull_x      <= cmd.out_zero ? '0 : cur_reg.x;
            vtx_word_reg.hull_y      <= cmd.out_zero ? '0 : cur_reg.y;
            vtx_word_reg.last_vertex <= cmd.out_last;
            vtx_word_reg.status      <= cmd.out_status;
        end
    end

    assign vtx_valid = vtx_valid_reg;
    assign vtx_word  = vtx_word_reg;

endmodule

// File: design/cgw_ctrl.sv
// Controller of the hull block: load counting, leftmost search, candidate
// scan sequencing and result emission. Depends on cgw_pkg.
module cgw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  logic           func,
    input  cgw_pkg::stat_t stat,
    output cgw_pkg::cmd_t  cmd
);

    cgw_pkg::state_t state_reg, state_next;
    logic [cgw_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [cgw_pkg::CNT_BITS-1:0] n_reg, n_next;
    logic [cgw_pkg::CNT_BITS-1:0] i_reg, i_next;
    logic [cgw_pkg::CNT_BITS-1:0] k_reg, k_next;
    logic [cgw_pkg::CNT_BITS-1:0] i_inc;
    logic                         ovf_reg, ovf_next;
    logic [1:0]                   st_reg, st_next;
    logic                         force_last_reg, force_last_next;
    logic                         empty_reg, empty_next;
    logic                         last_now;
    logic                         accept;

    assign cmd_stall = (state_reg != cgw_pkg::ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign i_inc     = i_reg + 1'b1;
    assign last_now  = force_last_reg || stat.stop_hit;

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        ovf_next        = ovf_reg;
        st_next         = st_reg;
        force_last_next = force_last_reg;
        empty_next      = empty_reg;
        cmd             = '0;
        cmd.mem_addr    = i_reg[cgw_pkg::IDX_BITS-1:0];
        cmd.out_last    = last_now;
        cmd.out_zero    = empty_reg;
        cmd.out_status  = empty_reg ? cgw_pkg::STATUS_EMPTY : st_reg;

        case (state_reg)
            cgw_pkg::ST_IDLE:
            begin
                cmd.mem_addr = count_reg[cgw_pkg::IDX_BITS-1:0];
                if (accept && (func == cgw_pkg::FUNC_LOAD))
                begin
                    if (count_reg < cgw_pkg::CNT_BITS'(cgw_pkg::MAX_POINTS))
                    begin
                        cmd.mem_we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (accept)
                begin
                    n_next          = count_reg;
                    st_next         = ovf_reg ? cgw_pkg::STATUS_OVERFLOW : cgw_pkg::STATUS_OK;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    i_next          = '0;
                    k_next          = '0;
                    if (count_reg == '0)
                    begin
                        empty_next      = 1'b1;
                        force_last_next = 1'b1;
                        state_next      = cgw_pkg::ST_EMIT;
                    end
                    else
                    begin
                        empty_next      = 1'b0;
                        force_last_next = 1'b0;
                        state_next      = cgw_pkg::ST_LEFT_RD;
                    end
                end
            end

            // Leftmost search: one read and one compare per point.
            cgw_pkg::ST_LEFT_RD:
            begin
                cmd.mem_re = 1'b1;
                state_next = cgw_pkg::ST_LEFT_CMP;
            end

            cgw_pkg::ST_LEFT_CMP:
            begin
                cmd.left_upd   = 1'b1;
                cmd.left_first = (i_reg == '0);
                i_next         = i_inc;
                state_next     = (i_inc == n_reg) ? cgw_pkg::ST_CHECK : cgw_pkg::ST_LEFT_RD;
            end

            // Before each scan, decide whether the vertex limit ends the walk.
            cgw_pkg::ST_CHECK:
            begin
                cmd.cur_from_start = (k_reg == '0);
                i_next             = '0;
                if (k_reg == cgw_pkg::CNT_BITS'(cgw_pkg::MAX_POINTS - 1))
                begin
                    force_last_next = 1'b1;
                    state_next      = cgw_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = cgw_pkg::ST_SCAN_RD;
                end
            end

            cgw_pkg::ST_SCAN_RD:
            begin
                cmd.mem_re = 1'b1;
                state_next = cgw_pkg::ST_SCAN_DIFF;
            end

            // The first point seeds the best candidate without a test.
            cgw_pkg::ST_SCAN_DIFF:
            begin
                if (i_reg == '0)
                begin
                    cmd.load_best = 1'b1;
                    i_next        = i_inc;
                    state_next    = (i_inc == n_reg) ? cgw_pkg::ST_EMIT : cgw_pkg::ST_SCAN_RD;
                end
                else
                begin
                    cmd.diff_en = 1'b1;
                    state_next  = cgw_pkg::ST_SCAN_MUL;
                end
            end

            cgw_pkg::ST_SCAN_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = cgw_pkg::ST_SCAN_CMP;
            end

            cgw_pkg::ST_SCAN_CMP:
            begin
                cmd.cmp_en = 1'b1;
                i_next     = i_inc;
                state_next = (i_inc == n_reg) ? cgw_pkg::ST_EMIT : cgw_pkg::ST_SCAN_RD;
            end

            // Emit the current vertex once the output register is free.
            cgw_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (last_now)
                    begin
                        state_next = cgw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        k_next      = k_reg + 1'b1;
                        state_next  = cgw_pkg::ST_CHECK;
                    end
                end
            end

            default:
            begin
                state_next = cgw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cgw_pkg::ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            ovf_reg        <= 1'b0;
            st_reg         <= cgw_pkg::STATUS_OK;
            force_last_reg <= 1'b0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            ovf_reg        <= ovf_next;
            st_reg         <= st_next;
            force_last_reg <= force_last_next;
            empty_reg      <= empty_next;
        end
    end

endmodule

// File: design/convex_hull_gift_wrap_top.sv
// Load word: the block takes one load word per cycle while idle (cmd_stall low).
// Run word: a leftmost search with a store read and a compare per point, then a
// candidate scan per hull vertex over the n stored points (a store read, a difference
// stage, a product stage and a compare per candidate), plus a limit check and an
// emit per emitted vertex; the emit waits while the output stalls.
// Reset clears the point count, overflow flag, controller and output valid;
// the point store itself needs no clearing.
module convex_hull_gift_wrap_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cgw_pkg::cmd_word_t cmd_word,
    output logic               vtx_valid,
    input  logic               vtx_stall,
    output cgw_pkg::vtx_word_t vtx_word
);

    cgw_pkg::cmd_t   cmd;
    cgw_pkg::stat_t  stat;
    cgw_pkg::point_t load_pt;

    assign load_pt.x = cmd_word.px;
    assign load_pt.y = cmd_word.py;

    // Sequencer.
    cgw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .func      (cmd_word.func),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Point store, geometry tests and output register.
    cgw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .load_pt   (load_pt),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx_word  (vtx_word)
    );

endmodule
